### sv/assert_macros.svh
// Assertion helpers for the sorted table unit.
// Each macro expands to a clocked concurrent assertion with a reset guard,
// or to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_CLK(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define ASSERT_NEVER(name, clk, rst, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(name, clk, rst, prop, msg)

`define ASSERT_NEVER(name, clk, rst, expr, msg)

`endif

`endif

### sv/stid_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stid_pkg
// Shared widths, codes and the cell command bundle of the sorted table unit.
// ----------------------------------------------------------------------------
package stid_pkg;

   localparam int VALUE_W       = 32;
   localparam int MODE_W        = 2;
   localparam int INDEX_W       = 6;
   localparam int STATUS_W      = 2;
   localparam int POS_W         = 6;
   localparam int COUNT_W       = 7;
   localparam int DEPTH_DEFAULT = 64;

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT = 2'd0,
      MODE_DELETE = 2'd1,
      MODE_READ   = 2'd2,
      MODE_NOP    = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_RANGE     = 2'd3
   } status_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic                      cmp_en;      // latch compare flags
      logic                      ins_en;      // shift up and insert
      logic                      del_en;      // shift down over the match
      logic signed [VALUE_W-1:0] cmp_value;   // value seen at accept
      logic signed [VALUE_W-1:0] apply_value; // value held for the update
   } cell_cmd_type;

endpackage
`default_nettype wire

### sv/stid_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stid_cell
// One slot of the ordered table: holds an entry, compares it against the
// broadcast value and shifts to or from its neighbors on insert or delete.
// ----------------------------------------------------------------------------
module stid_cell
   import stid_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   parameter int IDX   = 0,
   localparam int CNT_W = $clog2(DEPTH + 1),
   localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W
) (
   input  wire logic                      clock,
   input  wire cell_cmd_type              cmd,
   input  wire logic [CNT_W-1:0]          count,
   input  wire logic [INDEX_W-1:0]        index,
   input  wire logic signed [VALUE_W-1:0] left_entry,
   input  wire logic                      left_gt,
   input  wire logic signed [VALUE_W-1:0] right_entry,
   output logic signed [VALUE_W-1:0]      entry,
   output logic                           gt,
   output logic                           ge,
   output logic                           eq,
   output logic                           hit
);

   logic signed [VALUE_W-1:0] entry_ff, entry_in;
   logic                      gt_ff, ge_ff, eq_ff, hit_ff;
   logic                      valid;

   assign valid = CNT_W'(IDX) < count;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.ins_en) begin
         if (left_gt) begin
            entry_in = left_entry;
         end else if (gt_ff) begin
            entry_in = cmd.apply_value;
         end
      end else if (cmd.del_en && ge_ff) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (cmd.cmp_en) begin
         // empty slots count as larger so the first one takes a new value
         gt_ff  <= !valid || (cmd.cmp_value < entry_ff);
         ge_ff  <= valid && !(entry_ff < cmd.cmp_value);
         eq_ff  <= valid && (entry_ff == cmd.cmp_value);
         hit_ff <= CMP_W'(IDX) == CMP_W'(index);
      end
   end

   assign entry = entry_ff;
   assign gt    = gt_ff;
   assign ge    = ge_ff;
   assign eq    = eq_ff;
   assign hit   = hit_ff;

endmodule
`default_nettype wire

### sv/sorted_table_insert_delete_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_table_insert_delete_unit
// Ordered table of signed values with insert, delete and indexed read.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one transaction: mode (insert, delete, read, no-op), value, index.
//   rsp_* returns one result per transaction: status, position, value_out
//   and the entry count after the operation.
//   Each table slot is a cell of a chain. In the accept cycle every cell
//   compares its entry against req_value and latches flags; in the next
//   cycle the cells shift from their neighbors and the result is encoded
//   from the flags into the output register.
//   The result register loads at the end of the apply step that follows
//   the accept cycle.
//   No request is taken during the apply step, so a new transaction waits
//   until the compare and update steps of the cell chain are through.
//   A new request is taken while the previous result is still held, as long
//   as that result is taken in the same cycle; a stalled rsp_ready holds the
//   result and blocks further requests.
//   Reset empties the table (count zero); entry contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_table_insert_delete_unit
   import stid_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [MODE_W-1:0]         req_mode,
   input  wire logic signed [VALUE_W-1:0] req_value,
   input  wire logic [INDEX_W-1:0]        req_index,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [STATUS_W-1:0]            rsp_status,
   output logic [POS_W-1:0]               rsp_position,
   output logic signed [VALUE_W-1:0]      rsp_value_out,
   output logic [COUNT_W-1:0]             rsp_count
);

`include "assert_macros.svh"

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

   typedef enum logic {
      S_IDLE,
      S_APPLY
   } state_type;

   state_type                 state_ff, state_in;
   mode_type                  mode_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic [INDEX_W-1:0]        index_ff;
   logic [CNT_W-1:0]          count_ff, count_in;

   logic                      rsp_valid_ff;
   status_type                rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]          rsp_position_ff, rsp_position_in;
   logic signed [VALUE_W-1:0] rsp_value_ff, rsp_value_in;

   logic                      req_fire;
   cell_cmd_type              cmd;

   logic signed [VALUE_W-1:0] entry_vec [DEPTH];
   logic [DEPTH-1:0]          gt_vec, ge_vec, eq_vec, hit_vec;
   logic [DEPTH-1:0]          ins_edge, del_edge;
   logic [PTR_W-1:0]          ins_pos, del_pos;
   logic signed [VALUE_W-1:0] read_data;
   logic                      found, full, in_range;

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;

   assign full     = count_ff == CNT_W'(DEPTH);
   assign found    = |eq_vec;
   assign in_range = CMP_W'(index_ff) < CMP_W'(count_ff);

   always_comb begin
      cmd.cmp_en      = req_fire;
      cmd.ins_en      = (state_ff == S_APPLY) && (mode_ff == MODE_INSERT) && !full;
      cmd.del_en      = (state_ff == S_APPLY) && (mode_ff == MODE_DELETE) && found;
      cmd.cmp_value   = req_value;
      cmd.apply_value = value_ff;
   end

   // cell chain
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [VALUE_W-1:0] left_entry, right_entry;
      logic                      left_gt;

      if (i == 0) begin : g_first
         assign left_entry = '0;
         assign left_gt    = 1'b0;
      end else begin : g_mid
         assign left_entry = entry_vec[i-1];
         assign left_gt    = gt_vec[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_inner
         assign right_entry = entry_vec[i+1];
      end

      stid_cell #(
         .DEPTH (DEPTH),
         .IDX   (i)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .count       (count_ff),
         .index       (req_index),
         .left_entry  (left_entry),
         .left_gt     (left_gt),
         .right_entry (right_entry),
         .entry       (entry_vec[i]),
         .gt          (gt_vec[i]),
         .ge          (ge_vec[i]),
         .eq          (eq_vec[i]),
         .hit         (hit_vec[i])
      );
   end

   // flags are monotone along the sorted chain, so each edge vector has at most one bit set
   assign ins_edge = gt_vec & ~(gt_vec << 1);
   assign del_edge = ge_vec & ~(ge_vec << 1);

   always_comb begin
      ins_pos   = '0;
      del_pos   = '0;
      read_data = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (ins_edge[i]) ins_pos = ins_pos | PTR_W'(i);
         if (del_edge[i]) del_pos = del_pos | PTR_W'(i);
         if (hit_vec[i])  read_data = read_data | entry_vec[i];
      end
   end

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_position_in = rsp_position_ff;
      rsp_value_in    = rsp_value_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) state_in = S_APPLY;
         end
         S_APPLY: begin
            state_in        = S_IDLE;
            rsp_status_in   = ST_OK;
            rsp_position_in = '0;
            rsp_value_in    = '0;
            case (mode_ff)
               MODE_INSERT: begin
                  if (full) begin
                     rsp_status_in = ST_FULL;
                  end else begin
                     rsp_position_in = POS_W'(ins_pos);
                     count_in        = count_ff + CNT_W'(1);
                  end
               end
               MODE_DELETE: begin
                  if (!found) begin
                     rsp_status_in = ST_NOT_FOUND;
                  end else begin
                     rsp_position_in = POS_W'(del_pos);
                     count_in        = count_ff - CNT_W'(1);
                  end
               end
               MODE_READ: begin
                  if (!in_range) begin
                     rsp_status_in = ST_RANGE;
                  end else begin
                     rsp_value_in = read_data;
                  end
               end
               default: begin
               end
            endcase
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (state_ff == S_APPLY) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_fire) begin
         mode_ff  <= mode_type'(req_mode);
         value_ff <= req_value;
         index_ff <= req_index;
      end
      rsp_status_ff   <= rsp_status_in;
      rsp_position_ff <= rsp_position_in;
      rsp_value_ff    <= rsp_value_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_position  = rsp_position_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_count     = COUNT_W'(count_ff);

   `ASSERT_CLK(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH), "entry count beyond depth")
   `ASSERT_CLK(a_rsp_latency, clock, reset, req_fire |-> ##2 rsp_valid_ff, "result late")
   `ASSERT_CLK(a_order_kept, clock, reset, (state_ff == S_APPLY) |-> ($onehot0(ins_edge) && $onehot0(del_edge)), "table order broken")
   `ASSERT_NEVER(a_one_update, clock, reset, cmd.ins_en && cmd.del_en, "insert and delete in one cycle")

endmodule
`default_nettype wire

### tb/sorted_table_checker.sv
// ----------------------------------------------------------------------------
// sorted_table_checker
// Watches the request and response channels of the sorted table unit. Each
// accepted request updates a private copy of the ordered table and queues
// the expected response; each accepted response is compared field by field
// with the oldest queued one.
// ----------------------------------------------------------------------------
module sorted_table_checker
   import stid_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   input  wire logic                      req_ready,
   input  wire logic [MODE_W-1:0]         req_mode,
   input  wire logic signed [VALUE_W-1:0] req_value,
   input  wire logic [INDEX_W-1:0]        req_index,
   input  wire logic                      rsp_valid,
   input  wire logic                      rsp_ready,
   input  wire logic [STATUS_W-1:0]       rsp_status,
   input  wire logic [POS_W-1:0]          rsp_position,
   input  wire logic signed [VALUE_W-1:0] rsp_value_out,
   input  wire logic [COUNT_W-1:0]        rsp_count,
   output int                             mismatch_count,
   output int                             outstanding
);

   typedef struct packed {
      status_type                status;
      logic [POS_W-1:0]          position;
      logic signed [VALUE_W-1:0] value_out;
      logic [COUNT_W-1:0]        count;
   } table_result_type;

   logic signed [VALUE_W-1:0] shelf [DEPTH];
   int                        fill = 0;
   int                        errs = 0;
   table_result_type          expected_q [$];

   // applies one transaction to the table copy and returns its response
   function automatic table_result_type table_update(mode_type op,
                                                     logic signed [VALUE_W-1:0] v,
                                                     logic [INDEX_W-1:0] idx);
      table_result_type r;
      int               slot;
      int               i;
      r = '0;
      case (op)
         MODE_INSERT: begin
            if (fill >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               // new value lands after every equal entry
               slot = fill;
               for (i = 0; i < fill && slot == fill; i++)
                  if (v < shelf[i]) slot = i;
               for (i = fill; i > slot; i--)
                  shelf[i] = shelf[i-1];
               shelf[slot] = v;
               fill++;
               r.position = slot[POS_W-1:0];
            end
         end
         MODE_DELETE: begin
            slot = fill;
            for (i = 0; i < fill && slot == fill; i++)
               if (shelf[i] == v) slot = i;
            if (slot == fill) begin
               r.status = ST_NOT_FOUND;
            end else begin
               for (i = slot; i + 1 < fill; i++)
                  shelf[i] = shelf[i+1];
               fill--;
               r.position = slot[POS_W-1:0];
            end
         end
         MODE_READ: begin
            if (int'(idx) >= fill) r.status = ST_RANGE;
            else r.value_out = shelf[idx];
         end
         default: ;
      endcase
      r.count = fill[COUNT_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      table_result_type want;
      if (reset) begin
         fill = 0;
         expected_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $error("response with no transaction pending: status %0d count %0d",
                      rsp_status, rsp_count);
               errs++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_status !== want.status) begin
                  $error("rsp_status: expected %0d, actual %0d", want.status, rsp_status);
                  errs++;
               end
               if (rsp_position !== want.position) begin
                  $error("rsp_position: expected %0d, actual %0d",
                         want.position, rsp_position);
                  errs++;
               end
               if (rsp_value_out !== want.value_out) begin
                  $error("rsp_value_out: expected %0d, actual %0d",
                         want.value_out, rsp_value_out);
                  errs++;
               end
               if (rsp_count !== want.count) begin
                  $error("rsp_count: expected %0d, actual %0d", want.count, rsp_count);
                  errs++;
               end
            end
         end
         if (req_valid && req_ready)
            expected_q.push_back(table_update(mode_type'(req_mode), req_value, req_index));
      end
      mismatch_count <= errs;
      outstanding    <= expected_q.size();
   end

endmodule

### tb/tb_sorted_table_insert_delete_unit.sv
// ----------------------------------------------------------------------------
// tb_sorted_table_insert_delete_unit
// Drives the sorted table unit with directed corner transactions and then
// fill, drain and mixed random runs under three idling profiles; the
// checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_sorted_table_insert_delete_unit;
   import stid_pkg::*;

   localparam int TABLE_DEPTH   = DEPTH_DEFAULT;
   localparam int SETTLE_CYCLES = 8;

   typedef enum {MIX_FILL, MIX_DRAIN, MIX_ANY} op_mix_type;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [MODE_W-1:0]         req_mode  = MODE_NOP;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic [INDEX_W-1:0]        req_index = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [STATUS_W-1:0]       rsp_status;
   logic [POS_W-1:0]          rsp_position;
   logic signed [VALUE_W-1:0] rsp_value_out;
   logic [COUNT_W-1:0]        rsp_count;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int mismatch_count;
   int outstanding;

   // rough picture of the table contents, used only to aim deletes and reads
   logic signed [VALUE_W-1:0] live_vals [$];

   always #10 clock = ~clock;

   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);

   sorted_table_insert_delete_unit #(
      .DEPTH(TABLE_DEPTH)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_value     (req_value),
      .req_index     (req_index),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_position  (rsp_position),
      .rsp_value_out (rsp_value_out),
      .rsp_count     (rsp_count)
   );

   sorted_table_checker #(
      .DEPTH(TABLE_DEPTH)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_value      (req_value),
      .req_index      (req_index),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_position   (rsp_position),
      .rsp_value_out  (rsp_value_out),
      .rsp_count      (rsp_count),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   task automatic send_op(mode_type op, logic signed [VALUE_W-1:0] v,
                          logic [INDEX_W-1:0] idx);
      int k;
      int hit;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= op;
      req_value <= v;
      req_index <= idx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (op == MODE_INSERT && live_vals.size() < TABLE_DEPTH) begin
         live_vals.push_back(v);
      end else if (op == MODE_DELETE) begin
         hit = -1;
         for (k = 0; k < live_vals.size() && hit < 0; k++)
            if (live_vals[k] == v) hit = k;
         if (hit >= 0) live_vals.delete(hit);
      end
   endtask

   // full-range values, a small cluster for duplicates, and the extremes
   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(9))
         4, 5, 6: return $urandom_range(8) - 4;
         7: begin
            case ($urandom_range(3))
               0:       return 32'sh8000_0000;
               1:       return 32'sh7fff_ffff;
               2:       return '0;
               default: return '1;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_target();
      if (live_vals.size() > 0 && $urandom_range(99) < 85)
         return live_vals[$urandom_range(live_vals.size() - 1)];
      return pick_value();
   endfunction

   task automatic run_block(op_mix_type mix, int n_items);
      int                        j;
      int                        r;
      mode_type                  op;
      logic signed [VALUE_W-1:0] v;
      logic [INDEX_W-1:0]        idx;
      for (j = 0; j < n_items; j++) begin
         r = $urandom_range(99);
         case (mix)
            MIX_FILL: begin
               if (r < 85)      op = MODE_INSERT;
               else if (r < 95) op = MODE_READ;
               else             op = MODE_NOP;
            end
            MIX_DRAIN: begin
               if (r < 75)      op = MODE_DELETE;
               else if (r < 90) op = MODE_READ;
               else if (r < 95) op = MODE_INSERT;
               else             op = MODE_NOP;
            end
            default: begin
               if (r < 35)      op = MODE_INSERT;
               else if (r < 70) op = MODE_DELETE;
               else if (r < 95) op = MODE_READ;
               else             op = MODE_NOP;
            end
         endcase
         v = (op == MODE_DELETE) ? pick_target() : pick_value();
         // mostly aim within or just past the current count
         if ($urandom_range(99) < 70) idx = INDEX_W'($urandom_range(live_vals.size()));
         else idx = INDEX_W'($urandom_range(63));
         send_op(op, v, idx);
      end
   endtask

   task automatic run_directed();
      send_op(MODE_READ,   32'sd0, 6'd0);               // read on empty table
      send_op(MODE_DELETE, 32'sd5, 6'd0);               // delete on empty table
      send_op(MODE_NOP,    '1, 6'd63);
      send_op(MODE_INSERT, 32'sh7fff_ffff, 6'd0);
      send_op(MODE_INSERT, 32'sh8000_0000, 6'd0);
      send_op(MODE_INSERT, 32'sd0, 6'd0);
      send_op(MODE_INSERT, 32'sd0, 6'd0);               // lands after equal entry
      send_op(MODE_INSERT, -32'sd1, 6'd0);
      send_op(MODE_INSERT, 32'sd1, 6'd0);
      send_op(MODE_READ,   32'sd0, 6'd0);
      send_op(MODE_READ,   32'sd0, 6'd5);
      send_op(MODE_READ,   32'sd0, 6'd6);               // index equal to the count, first out of range
      send_op(MODE_READ,   32'sd0, 6'd63);
      send_op(MODE_DELETE, 32'sd0, 6'd0);               // first of two equal
      send_op(MODE_DELETE, 32'sd7, 6'd0);               // absent value
      send_op(MODE_DELETE, 32'sh8000_0000, 6'd0);
      send_op(MODE_DELETE, 32'sh7fff_ffff, 6'd0);
      send_op(MODE_NOP,    32'sd0, 6'd0);
      send_op(MODE_READ,   32'sd0, 6'd2);
      send_op(MODE_INSERT, 32'sd1, 6'd0);
   endtask

   initial begin
      int ph;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      for (ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               send_idle_pct = 14;
               rsp_stall_pct = 75;
               run_directed();
            end
            1: begin
               send_idle_pct = 75;
               rsp_stall_pct = 14;
            end
            default: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
         endcase
         run_block(MIX_FILL, 90);
         run_block(MIX_DRAIN, 90);
         run_block(MIX_ANY, 100);
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("sorted_table_insert_delete_unit regression: pass");
      else
         $display("sorted_table_insert_delete_unit regression: fail");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("sorted_table_insert_delete_unit regression: fail");
      $finish;
   end

endmodule

### sorted_table_insert_delete_unit.f
+incdir+sv
sv/stid_pkg.sv
sv/stid_cell.sv
sv/sorted_table_insert_delete_unit.sv
tb/sorted_table_checker.sv
tb/tb_sorted_table_insert_delete_unit.sv
